@@ hdl/psort_pkg.sv @@
package psort_pkg;

    localparam int MaxNodes = 64;
    localparam int Dim      = 3;

    localparam int CoordW = 24;
    localparam int ProdW  = 2 * CoordW;
    localparam int KeyW   = ProdW + 2;
    localparam int IdxW   = 6;
    localparam int CountW = $clog2(MaxNodes + 1);
    localparam int RankW  = $clog2(MaxNodes);

    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegVelX = 2'd0;
    localparam logic [CfgIdxW-1:0] RegVelY = 2'd1;
    localparam logic [CfgIdxW-1:0] RegVelZ = 2'd2;

    localparam int InDataW  = 80;
    localparam int OutDataW = 16;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic insert;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic              rank_last;
        logic              count_zero;
        logic              out_valid;
        logic [CountW-1:0] count;
    } stat_t;

endpackage

@@ hdl/projection_sort_ordering_unit.sv @@
// Downwind ordering unit. Each node transfer carries a position and an
// unknown's index; the block keys it by the dot product of the position with
// the configured velocity (signed Q8.16, exact 50-bit key) and inserts it into
// a row of 64 compare-and-shift cells that keeps the keys in ascending order,
// equal keys in arrival order. A stored node goes through capture, three
// parallel multiplies, sum and insert into the cell row; a node that arrives
// with 64 already stored is dropped and flags overflow. After the node with
// tlast, the block sends one (index, rank) pair per cycle while the sink is
// ready, n transfers for n stored nodes, then accepts the next set. The user
// must write velocity registers only while idle; the block won't enforce it.
module projection_sort_ordering_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psort_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [psort_pkg::CoordW-1:0]        cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], node_index[77:72], zero fill
    input  logic [psort_pkg::InDataW-1:0]       s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_index[5:0], out_rank[11:6], overflow[12], zero fill
    output logic [psort_pkg::OutDataW-1:0]      m_tdata,
    output logic                                m_tlast
);

    psort_pkg::cmd_t  cmd;
    psort_pkg::stat_t stat;

    psort_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    psort_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= psort_pkg::CountW'(psort_pkg::MaxNodes))
        else $error("node count above capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> stat.count == $past(stat.count) + psort_pkg::CountW'(1))
        else $error("insert did not advance node count");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwritten before transfer");

    a_no_input_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !s_tready)
        else $error("input open while sending results");

endmodule

@@ hdl/psort_ctrl.sv @@
module psort_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    input  logic             m_tready,
    input  psort_pkg::stat_t stat,
    output logic             s_tready,
    output psort_pkg::cmd_t  cmd
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMul  = 3'd1;
    localparam logic [2:0] StSum  = 3'd2;
    localparam logic [2:0] StIns  = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       last_reg;
    logic       last_next;
    logic       accept;
    logic       slot_free;

    assign s_tready  = (state_reg == StIdle);
    assign accept    = s_tready && s_tvalid;
    assign slot_free = !stat.out_valid || m_tready;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            StIdle:
            begin
                if (accept)
                begin
                    cmd.load  = 1'b1;
                    last_next = s_tlast;
                    if (!stat.full)
                        state_next = StMul;
                    else if (s_tlast)
                        state_next = StOut;
                end
            end
            StMul:
            begin
                cmd.mul    = 1'b1;
                state_next = StSum;
            end
            StSum:
            begin
                cmd.sum    = 1'b1;
                state_next = StIns;
            end
            StIns:
            begin
                cmd.insert = 1'b1;
                state_next = last_reg ? StOut : StIdle;
            end
            StOut:
            begin
                if (stat.count_zero)
                begin
                    cmd.finish = 1'b1;
                    state_next = StIdle;
                end
                else if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.rank_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = StIdle;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

@@ hdl/psort_dp.sv @@
module psort_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psort_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [psort_pkg::CoordW-1:0]        cfg_data,
    input  logic [psort_pkg::InDataW-1:0]       s_tdata,
    input  logic                                m_tready,
    input  psort_pkg::cmd_t                     cmd,
    output psort_pkg::stat_t                    stat,
    output logic                                m_tvalid,
    output logic [psort_pkg::OutDataW-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int N  = psort_pkg::MaxNodes;
    localparam int CW = psort_pkg::CountW;
    localparam int RW = psort_pkg::RankW;
    localparam int KW = psort_pkg::KeyW;
    localparam int PW = psort_pkg::ProdW;
    localparam int XW = psort_pkg::CoordW;
    localparam int IW = psort_pkg::IdxW;

    logic signed [XW-1:0] vel_x_reg;
    logic signed [XW-1:0] vel_y_reg;
    logic signed [XW-1:0] vel_z_reg;

    logic signed [XW-1:0] pos_x_reg;
    logic signed [XW-1:0] pos_y_reg;
    logic signed [XW-1:0] pos_z_reg;
    logic [IW-1:0]        idx_reg;

    logic signed [PW-1:0] prod_x_reg;
    logic signed [PW-1:0] prod_y_reg;
    logic signed [PW-1:0] prod_z_reg;
    logic signed [KW-1:0] key_reg;

    logic [CW-1:0] count_reg;
    logic [RW-1:0] rank_reg;
    logic          overflow_reg;

    logic signed [KW-1:0] key_cell_reg [N];
    logic [IW-1:0]        idx_cell_reg [N];
    logic [N-1:0]         gt;

    logic          out_valid_reg;
    logic [IW-1:0] out_index_reg;
    logic [5:0]    out_rank_reg;
    logic          out_ovf_reg;
    logic          out_last_reg;

    logic full;
    logic rank_last;

    assign full      = (count_reg == CW'(N));
    assign rank_last = ((CW'(rank_reg) + CW'(1)) == count_reg);

    assign stat.full       = full;
    assign stat.rank_last  = rank_last;
    assign stat.count_zero = (count_reg == '0);
    assign stat.out_valid  = out_valid_reg;
    assign stat.count      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            vel_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psort_pkg::RegVelX: vel_x_reg <= cfg_data;
                psort_pkg::RegVelY: vel_y_reg <= cfg_data;
                psort_pkg::RegVelZ: vel_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // key pipeline: input capture, three products, sum
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_x_reg <= s_tdata[XW-1:0];
            pos_y_reg <= s_tdata[2*XW-1:XW];
            pos_z_reg <= s_tdata[3*XW-1:2*XW];
            idx_reg   <= s_tdata[3*XW+IW-1:3*XW];
        end
        if (cmd.mul)
        begin
            prod_x_reg <= pos_x_reg * vel_x_reg;
            prod_y_reg <= pos_y_reg * vel_y_reg;
            prod_z_reg <= pos_z_reg * vel_z_reg;
        end
        if (cmd.sum)
        begin
            key_reg <= KW'(prod_x_reg)
                     + ((psort_pkg::Dim >= 2) ? KW'(prod_y_reg) : KW'(0))
                     + ((psort_pkg::Dim >= 3) ? KW'(prod_z_reg) : KW'(0));
        end
    end

    // occupied cells hold keys in ascending order; gt marks cells above the new key
    always_comb
    begin
        for (int i = 0; i < N; i++)
            gt[i] = (CW'(i) < count_reg) && (key_cell_reg[i] > key_reg);
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        logic signed [KW-1:0] key_dn;
        logic [IW-1:0]        idx_dn;
        logic signed [KW-1:0] key_up;
        logic [IW-1:0]        idx_up;
        logic                 take_prev;
        logic                 wr;

        if (g == 0)
        begin : g_first
            assign take_prev = 1'b0;
            assign key_dn    = key_reg;
            assign idx_dn    = idx_reg;
        end
        else
        begin : g_rest
            assign take_prev = gt[g-1];
            assign key_dn    = key_cell_reg[g-1];
            assign idx_dn    = idx_cell_reg[g-1];
        end

        if (g == N - 1)
        begin : g_tail
            assign key_up = key_cell_reg[g];
            assign idx_up = idx_cell_reg[g];
        end
        else
        begin : g_body
            assign key_up = key_cell_reg[g+1];
            assign idx_up = idx_cell_reg[g+1];
        end

        // stable insert: new key lands just past every key not above it
        assign wr = cmd.insert && (gt[g] || (count_reg == CW'(g)));

        always_ff @(posedge clk)
        begin
            if (wr)
            begin
                key_cell_reg[g] <= take_prev ? key_dn : key_reg;
                idx_cell_reg[g] <= take_prev ? idx_dn : idx_reg;
            end
            else if (cmd.emit)
            begin
                key_cell_reg[g] <= key_up;
                idx_cell_reg[g] <= idx_up;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rank_reg     <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && full)
                overflow_reg <= 1'b1;
            if (cmd.insert)
                count_reg <= count_reg + CW'(1);
            if (cmd.emit)
                rank_reg <= rank_reg + RW'(1);
            if (cmd.finish)
            begin
                count_reg    <= '0;
                rank_reg     <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_index_reg <= idx_cell_reg[0];
            out_rank_reg  <= 6'(rank_reg);
            out_ovf_reg   <= overflow_reg;
            out_last_reg  <= rank_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_ovf_reg, out_rank_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ test/projection_sort_ordering_unit_test.sv @@
module projection_sort_ordering_unit_test;

    localparam int CoordW   = psort_pkg::CoordW;
    localparam int KeyW     = psort_pkg::KeyW;
    localparam int IdxW     = psort_pkg::IdxW;
    localparam int RankW    = psort_pkg::RankW;
    localparam int CfgIdxW  = psort_pkg::CfgIdxW;
    localparam int InDataW  = psort_pkg::InDataW;
    localparam int OutDataW = psort_pkg::OutDataW;
    localparam int MaxNodes = psort_pkg::MaxNodes;

    localparam logic [CfgIdxW-1:0] RegVelX = psort_pkg::RegVelX;
    localparam logic [CfgIdxW-1:0] RegVelY = psort_pkg::RegVelY;
    localparam logic [CfgIdxW-1:0] RegVelZ = psort_pkg::RegVelZ;

    localparam logic signed [CoordW-1:0] MaxCoord = {1'b0, {(CoordW-1){1'b1}}};
    localparam logic signed [CoordW-1:0] MinCoord = {1'b1, {(CoordW-1){1'b0}}};
    // index 3 decodes to no register; writes to it must be ignored
    localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

    localparam int ItemsTarget  = 280;
    localparam int QuietFrom    = 240;
    localparam int PauseCycles  = 8;
    localparam int EndCycles    = 16;
    localparam int LongHold     = 400;
    localparam int WatchLimit   = 5000;

    typedef struct {
        logic [IdxW-1:0]  index;
        logic [RankW-1:0] rank;
        logic             overflow;
        logic             last;
    } rank_pair_t;

    class permutation_checker;
        logic signed [CoordW-1:0] vel_x = '0;
        logic signed [CoordW-1:0] vel_y = '0;
        logic signed [CoordW-1:0] vel_z = '0;
        logic signed [KeyW-1:0]   sorted_keys[$];
        logic [IdxW-1:0]          sorted_index[$];
        bit                       dropped;
        rank_pair_t               expected_pairs[$];
        int                       errors;

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
            case (idx)
                RegVelX: vel_x = data;
                RegVelY: vel_y = data;
                RegVelZ: vel_z = data;
                default: ;
            endcase
        endfunction

        function void note_node(logic [InDataW-1:0] data, logic last);
            logic signed [CoordW-1:0] px;
            logic signed [CoordW-1:0] py;
            logic signed [CoordW-1:0] pz;
            logic signed [KeyW-1:0]   key;
            rank_pair_t               p;
            int                       pos;
            int                       n;
            px = data[CoordW-1:0];
            py = data[2*CoordW-1:CoordW];
            pz = data[3*CoordW-1:2*CoordW];
            key = px * vel_x + py * vel_y + pz * vel_z;
            if (sorted_keys.size() < MaxNodes)
            begin
                // equal keys stay behind earlier arrivals
                pos = sorted_keys.size();
                while (pos > 0 && sorted_keys[pos-1] > key)
                    pos--;
                sorted_keys.insert(pos, key);
                sorted_index.insert(pos, data[3*CoordW+IdxW-1:3*CoordW]);
            end
            else
            begin
                dropped = 1'b1;
            end
            if (last)
            begin
                n = sorted_keys.size();
                for (int k = 0; k < n; k++)
                begin
                    p.index    = sorted_index[k];
                    p.rank     = RankW'(k);
                    p.overflow = dropped;
                    p.last     = (k == n - 1);
                    expected_pairs.push_back(p);
                end
                sorted_keys.delete();
                sorted_index.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_pair(logic [OutDataW-1:0] data, logic last);
            rank_pair_t want;
            if (expected_pairs.size() == 0)
            begin
                $error("out_index: unexpected transfer, expected none, got %0d",
                       data[IdxW-1:0]);
                errors++;
                return;
            end
            want = expected_pairs.pop_front();
            if (data[IdxW-1:0] !== want.index)
            begin
                $error("out_index: expected %0d, got %0d", want.index, data[IdxW-1:0]);
                errors++;
            end
            if (data[IdxW+RankW-1:IdxW] !== want.rank)
            begin
                $error("out_rank: expected %0d, got %0d", want.rank,
                       data[IdxW+RankW-1:IdxW]);
                errors++;
            end
            if (data[IdxW+RankW] !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow,
                       data[IdxW+RankW]);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_result: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CfgIdxW-1:0]    cfg_index = '0;
    logic [CoordW-1:0]     cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OutDataW-1:0]   m_tdata;
    logic                  m_tlast;

    permutation_checker sb = new;
    int                 items_sent;
    int                 idle_cycles;
    bit                 idling;
    bit                 hold_request;

    projection_sort_ordering_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one place sees both sides, so a node is noted before any result it causes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_node(s_tdata, s_tlast);
            if (m_tvalid === 1'b1 && m_tready)
                sb.check_pair(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchLimit)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // sink side: random stall bursts, plus one long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic signed [CoordW-1:0] pick_coord(int mode);
        logic signed [CoordW-1:0] v;
        case (mode)
            0: v = CoordW'($urandom);
            1: v = CoordW'($signed($urandom_range(0, 6)) - 3);
            default:
                case ($urandom_range(0, 4))
                    0: v = MaxCoord;
                    1: v = MinCoord;
                    2: v = CoordW'(0);
                    3: v = CoordW'(1);
                    default: v = CoordW'(-1);
                endcase
        endcase
        return v;
    endfunction

    task automatic send_node(logic [CoordW-1:0] px, logic [CoordW-1:0] py,
                             logic [CoordW-1:0] pz, logic [IdxW-1:0] idx, logic last);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InDataW-3*CoordW-IdxW){1'b0}}, idx, pz, py, px};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // the block is done once it takes input again with no result left to send
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (s_tready !== 1'b1 || m_tvalid !== 1'b0 || sb.expected_pairs.size() != 0);
        repeat (PauseCycles) @(posedge clk);
    endtask

    task automatic run_set(int count, bit hold_at_end);
        int mode;
        mode = $urandom_range(0, 3);
        if (mode == 3)
            mode = 0;
        for (int i = 0; i < count; i++)
        begin
            if (hold_at_end && i == count - 1)
                hold_request = 1'b1;
            send_node(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                      IdxW'($urandom_range(0, 63)), i == count - 1);
        end
    endtask

    task automatic run_directed();
        // velocity still zero from reset: all keys tie, arrival order holds,
        // repeated index too
        send_node(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), IdxW'(5), 1'b0);
        send_node(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), IdxW'(63), 1'b0);
        send_node(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), IdxW'(0), 1'b0);
        send_node(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), IdxW'(5), 1'b1);
        drain();
        write_reg(RegVelX, MaxCoord);
        write_reg(RegVelY, MinCoord);
        write_reg(RegVelZ, CoordW'(1));
        write_reg(RegSpare, CoordW'($urandom));
        cfg_we <= 1'b0;
        // one-node set
        send_node(MaxCoord, MaxCoord, MaxCoord, IdxW'(63), 1'b1);
        send_node(MaxCoord, MaxCoord, MaxCoord, IdxW'(0), 1'b0);
        send_node(MinCoord, MinCoord, MinCoord, IdxW'(1), 1'b0);
        send_node(CoordW'(0), CoordW'(0), CoordW'(0), IdxW'(2), 1'b0);
        send_node(MinCoord, MaxCoord, CoordW'(0), IdxW'(3), 1'b0);
        send_node(MaxCoord, MinCoord, MinCoord, IdxW'(4), 1'b0);
        send_node(CoordW'(0), CoordW'(0), MaxCoord, IdxW'(5), 1'b0);
        send_node(CoordW'(0), CoordW'(0), MinCoord, IdxW'(6), 1'b1);
        drain();
        write_reg(RegVelX, MinCoord);
        write_reg(RegVelY, MinCoord);
        write_reg(RegVelZ, MinCoord);
        cfg_we <= 1'b0;
        // largest possible key magnitude
        send_node(MinCoord, MinCoord, MinCoord, IdxW'(10), 1'b0);
        send_node(MaxCoord, MaxCoord, MaxCoord, IdxW'(11), 1'b0);
        send_node(CoordW'(1), CoordW'(-1), CoordW'(0), IdxW'(12), 1'b0);
        send_node(MinCoord, MinCoord, MinCoord, IdxW'(13), 1'b1);
    endtask

    initial
    begin
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idling = 1'b1;
        run_directed();
        phase = 0;
        while (items_sent < ItemsTarget)
        begin
            drain();
            idling = (items_sent < QuietFrom) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(RegVelX, pick_coord($urandom_range(0, 2)));
            if ($urandom_range(0, 3) != 0)
                write_reg(RegVelY, pick_coord($urandom_range(0, 2)));
            if ($urandom_range(0, 3) != 0)
                write_reg(RegVelZ, pick_coord($urandom_range(0, 2)));
            if ($urandom_range(0, 5) == 0)
                write_reg(RegSpare, CoordW'($urandom));
            cfg_we <= 1'b0;
            case (phase)
                // full store, sink held off while the next set is offered
                1:
                begin
                    run_set(MaxNodes, 1'b1);
                    run_set($urandom_range(1, 8), 1'b0);
                end
                // last node is the first one dropped
                3: run_set(MaxNodes + 1, 1'b0);
                5: run_set(MaxNodes + $urandom_range(2, 6), 1'b0);
                default:
                    repeat ($urandom_range(1, 3)) run_set($urandom_range(1, 8), 1'b0);
            endcase
            phase++;
        end
        drain();
        repeat (EndCycles) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
